### hw/rtl/cfr_pkg.sv
// cfr_pkg: shared types, constants and the crc-32c byte update for the frame receiver
// no dependencies; used by every module under hw/rtl except cfr_in_stage
package cfr_pkg;

	// header layout
	localparam int HEADER_BYTES = 16;
	localparam int POS_W        = 5;

	localparam logic [POS_W-1:0] POS_MAGIC   = 5'd4;
	localparam logic [POS_W-1:0] POS_VERSION = 5'd6;
	localparam logic [POS_W-1:0] POS_TYPE    = 5'd8;
	localparam logic [POS_W-1:0] POS_LENGTH  = 5'd12;
	localparam logic [POS_W-1:0] POS_CRC_END = 5'd12;
	localparam logic [POS_W-1:0] POS_LAST    = POS_W'(HEADER_BYTES);

	localparam logic [31:0] FRAME_MAGIC = 32'h494F_4246;
	localparam logic [31:0] CRC_POLY    = 32'h82F6_3B78;
	localparam logic [31:0] CRC_INIT    = 32'hFFFF_FFFF;

	// frame status codes
	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_MAGIC   = 3'd1;
	localparam logic [2:0] ST_VERSION = 3'd2;
	localparam logic [2:0] ST_SIZE    = 3'd3;
	localparam logic [2:0] ST_CRC     = 3'd4;

	// configuration register indexes, other indexes are ignored
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_VERSION = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD      = 2'd1;

	// one result word
	typedef struct packed {
		logic [15:0] msg_type;
		logic [7:0]  data_byte;
		logic        byte_valid;
		logic        frame_end;
		logic [2:0]  status;
	} result_t;

	// reflected crc-32c, one byte per call, eight bit steps
	function automatic logic [31:0] crc32c_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

### hw/rtl/cfr_in_stage.sv
// cfr_in_stage: input register for received bytes
// depends on: nothing beyond the valid/stall handshake
module cfr_in_stage (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [7:0] rx_byte,
	output logic       in_stall,
	input  logic       take,
	output logic       valid_s1,
	output logic [7:0] byte_s1
);

	// stall only while a held word cannot move on
	assign in_stall = valid_s1 && !take;

	// control bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	// payload, loaded only when a word is accepted
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= rx_byte;
		end
	end

endmodule

### hw/rtl/cfr_parser.sv
// cfr_parser: header parse, length count, running crc-32c and status for each byte
// depends on: cfr_pkg
module cfr_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                take,
	input  logic [7:0]          byte_s1,
	input  logic [15:0]         expected_version,
	input  logic [31:0]         max_payload,
	output logic                res_valid,
	output cfr_pkg::result_t    res
);

	logic [cfr_pkg::POS_W-1:0] pos_q, pos_n;
	logic                      in_payload_q, in_payload_n;
	logic [31:0]               header_word_q, header_word_n;
	logic [15:0]               frame_type_q, frame_type_n;
	logic [31:0]               remaining_q, remaining_n;
	logic [31:0]               stored_crc_q, stored_crc_n;
	logic [31:0]               crc_q, crc_n;
	logic [2:0]                fault_q, fault_n;
	logic [31:0]               crc_upd;
	logic                      restart;

	assign crc_upd = cfr_pkg::crc32c_byte(crc_q, byte_s1);

	// next state and result for the word in the input register
	always_comb begin
		pos_n         = pos_q;
		in_payload_n  = in_payload_q;
		header_word_n = header_word_q;
		frame_type_n  = frame_type_q;
		remaining_n   = remaining_q;
		stored_crc_n  = stored_crc_q;
		crc_n         = crc_q;
		fault_n       = fault_q;
		restart       = 1'b0;
		res_valid     = 1'b0;
		res.msg_type  = frame_type_q;
		res.data_byte = 8'd0;
		res.byte_valid = 1'b0;
		res.frame_end = 1'b0;
		res.status    = cfr_pkg::ST_OK;

		if (in_payload_q) begin
			// payload word passes straight through
			crc_n          = crc_upd;
			remaining_n    = remaining_q - 32'd1;
			res_valid      = 1'b1;
			res.data_byte  = byte_s1;
			res.byte_valid = 1'b1;
			if (remaining_n == 32'd0) begin
				res.frame_end = 1'b1;
				res.status    = ((~crc_upd) == stored_crc_q) ? cfr_pkg::ST_OK
				                                             : cfr_pkg::ST_CRC;
				restart       = 1'b1;
			end
		end else begin
			// header word: shift in, check fields as they complete
			if (pos_q < cfr_pkg::POS_CRC_END) begin
				crc_n = crc_upd;
			end
			header_word_n = {byte_s1, header_word_q[31:8]};
			pos_n         = pos_q + 1'b1;
			unique case (pos_n)
				cfr_pkg::POS_MAGIC: begin
					if (header_word_n != cfr_pkg::FRAME_MAGIC && fault_q == cfr_pkg::ST_OK)
						fault_n = cfr_pkg::ST_MAGIC;
				end
				cfr_pkg::POS_VERSION: begin
					if (header_word_n[31:16] != expected_version && fault_q == cfr_pkg::ST_OK)
						fault_n = cfr_pkg::ST_VERSION;
				end
				cfr_pkg::POS_TYPE: begin
					frame_type_n = header_word_n[31:16];
				end
				cfr_pkg::POS_LENGTH: begin
					remaining_n = header_word_n;
					if (header_word_n > max_payload && fault_q == cfr_pkg::ST_OK)
						fault_n = cfr_pkg::ST_SIZE;
				end
				default: ;
			endcase

			// end of header
			if (pos_n == cfr_pkg::POS_LAST) begin
				stored_crc_n = header_word_n;
				res.msg_type = frame_type_n;
				if (fault_n != cfr_pkg::ST_OK) begin
					res_valid     = 1'b1;
					res.frame_end = 1'b1;
					res.status    = fault_n;
					restart       = 1'b1;
				end else if (remaining_n == 32'd0) begin
					res_valid     = 1'b1;
					res.frame_end = 1'b1;
					res.status    = ((~crc_n) == header_word_n) ? cfr_pkg::ST_OK
					                                            : cfr_pkg::ST_CRC;
					restart       = 1'b1;
				end else begin
					in_payload_n = 1'b1;
					pos_n        = '0;
				end
			end
		end

		// back to waiting for a header
		if (restart) begin
			pos_n         = '0;
			in_payload_n  = 1'b0;
			header_word_n = '0;
			remaining_n   = '0;
			crc_n         = cfr_pkg::CRC_INIT;
			fault_n       = cfr_pkg::ST_OK;
		end
	end

	// frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q         <= '0;
			in_payload_q  <= 1'b0;
			header_word_q <= '0;
			frame_type_q  <= '0;
			remaining_q   <= '0;
			stored_crc_q  <= '0;
			crc_q         <= cfr_pkg::CRC_INIT;
			fault_q       <= cfr_pkg::ST_OK;
		end else if (take) begin
			pos_q         <= pos_n;
			in_payload_q  <= in_payload_n;
			header_word_q <= header_word_n;
			frame_type_q  <= frame_type_n;
			remaining_q   <= remaining_n;
			stored_crc_q  <= stored_crc_n;
			crc_q         <= crc_n;
			fault_q       <= fault_n;
		end
	end

endmodule

### hw/rtl/cfr_out_stage.sv
// cfr_out_stage: result register on the output channel
// depends on: cfr_pkg
module cfr_out_stage (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  logic             res_valid,
	input  cfr_pkg::result_t res,
	input  logic             out_stall,
	output logic             out_free,
	output logic             out_valid,
	output cfr_pkg::result_t res_q
);

	logic out_valid_q;

	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	// control bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= load && res_valid;
		end
	end

	// result word, held while stalled
	always_ff @(posedge clk) begin
		if (out_free && load && res_valid) begin
			res_q <= res;
		end
	end

endmodule

### hw/rtl/crc32c_frame_receiver.sv
// crc32c_frame_receiver: top level of the length-prefixed frame receiver
// depends on: cfr_pkg, cfr_in_stage, cfr_parser, cfr_out_stage
//
// Received bytes enter on in_valid/in_stall/rx_byte, one word per cycle while in_stall is low.
// Each frame opens with a 16-byte little-endian header (magic, version,
// type, length, stored crc-32c); payload words then leave on
// out_valid/out_stall with msg_type, data_byte, byte_valid, frame_end and
// status. Header bytes give no output word except the sixteenth, which
// reports a header error or an empty frame. The last word of a frame
// carries frame_end and the crc status.
// A taken byte passes through an input register and a result register,
// with the byte-wide crc update and header checks between them; out_valid
// comes from the result register. One byte is taken every cycle while the
// output drains.
// When out_stall holds a waiting word, the next byte is still taken into
// the input register; in_stall rises only once both registers are full.
// Reset clears both registers, returns the parser to the first header
// byte and loads expected_version 1 and max_payload 1048576.
// cfg_we/cfg_index/cfg_data write a register; index 0 is expected_version
// (low 16 bits), index 1 is max_payload, others are ignored.
module crc32c_frame_receiver (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [7:0]                     rx_byte,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [15:0]                    msg_type,
	output logic [7:0]                     data_byte,
	output logic                           byte_valid,
	output logic                           frame_end,
	output logic [2:0]                     status,
	input  logic                           cfg_we,
	input  logic [cfr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [31:0]                    cfg_data
);

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             take;
	logic             out_free;
	logic             res_valid;
	cfr_pkg::result_t res;
	cfr_pkg::result_t res_q;
	logic [15:0]      expected_version_q;
	logic [31:0]      max_payload_q;

	// a held word moves on whenever the result register can take it
	assign take = valid_s1 && out_free;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_version_q <= 16'd1;
			max_payload_q      <= 32'd1048576;
		end else if (cfg_we) begin
			unique case (cfg_index)
				cfr_pkg::CFG_EXPECTED_VERSION: expected_version_q <= cfg_data[15:0];
				cfr_pkg::CFG_MAX_PAYLOAD:      max_payload_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	cfr_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.rx_byte  (rx_byte),
		.in_stall (in_stall),
		.take     (take),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	cfr_parser u_parser (
		.clk              (clk),
		.arst_n           (arst_n),
		.take             (take),
		.byte_s1          (byte_s1),
		.expected_version (expected_version_q),
		.max_payload      (max_payload_q),
		.res_valid        (res_valid),
		.res              (res)
	);

	cfr_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (take),
		.res_valid (res_valid),
		.res       (res),
		.out_stall (out_stall),
		.out_free  (out_free),
		.out_valid (out_valid),
		.res_q     (res_q)
	);

	assign msg_type   = res_q.msg_type;
	assign data_byte  = res_q.data_byte;
	assign byte_valid = res_q.byte_valid;
	assign frame_end  = res_q.frame_end;
	assign status     = res_q.status;

`ifndef SYNTH
	// a word that does not close a frame is always a clean payload byte
	a_mid_frame_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !frame_end |-> byte_valid && status == cfr_pkg::ST_OK)
		else $error("mid-frame word without payload or with status");

	// a word without payload must close the frame
	a_empty_ends: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !byte_valid |-> frame_end)
		else $error("word without payload does not end the frame");

	// header errors never carry a payload byte
	a_hdr_err_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == cfr_pkg::ST_MAGIC || status == cfr_pkg::ST_VERSION ||
		status == cfr_pkg::ST_SIZE) |-> !byte_valid && data_byte == 8'd0)
		else $error("header error reported on a payload word");

	// input back-pressure comes only from a stalled full output
	a_stall_source: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid && out_stall)
		else $error("input stalled without output back-pressure");
`endif

endmodule

### test/crc32c_frame_receiver_test.sv
// crc32c_frame_receiver_test: self-checking bench for the crc-32c frame receiver
// depends on cfr_pkg and crc32c_frame_receiver; directed frames from a table, then random
// frames, noise and cut headers under several register settings, checked by a local parser
`timescale 1ns / 100ps

module crc32c_frame_receiver_test;

	localparam logic [31:0] MAGIC_WORD = 32'h494F_4246;
	localparam logic [31:0] POLY_REFL  = 32'h82F6_3B78;
	localparam logic [31:0] CRC_SEED   = 32'hFFFF_FFFF;
	localparam int HDR_BYTES   = 16;
	localparam int CRC_SPAN    = 12;
	localparam int MAX_BODY    = 64;
	localparam int SETTLE      = 6;
	localparam int LIMIT       = 400000;
	localparam int PHASES      = 6;
	localparam int PHASE_BYTES = 210;

	localparam logic [4:0] AT_MAGIC   = 5'd4;
	localparam logic [4:0] AT_VERSION = 5'd6;
	localparam logic [4:0] AT_KIND    = 5'd8;
	localparam logic [4:0] AT_LENGTH  = 5'd12;

	typedef enum logic [1:0] {FILL_RAND, FILL_ZERO, FILL_ONES} fill_t;

	typedef struct packed {
		logic [31:0] magic;
		logic [15:0] version;
		logic [15:0] kind;
		logic [31:0] length;
		logic        bad_crc;
		fill_t       fill;
		logic        typed;
		logic [2:0]  want;
	} frame_row_t;

	localparam int ROWS = 15;

	// directed frames, run with the reset register values
	frame_row_t plan [ROWS] = '{
		'{MAGIC_WORD, 16'h0001, 16'h1234, 32'd4, 1'b0, FILL_RAND, 1'b1, cfr_pkg::ST_OK},
		'{32'h494F_4247, 16'h0001, 16'h0042, 32'd4, 1'b0, FILL_RAND, 1'b1, cfr_pkg::ST_MAGIC},
		'{32'hFFFF_FFFF, 16'h0001, 16'hFFFF, 32'd0, 1'b0, FILL_RAND, 1'b1, cfr_pkg::ST_MAGIC},
		// magic fault wins over version and length
		'{32'h0, 16'h0000, 16'h0000, 32'hFFFF_FFFF, 1'b0, FILL_RAND, 1'b1, cfr_pkg::ST_MAGIC},
		// version fault wins over length
		'{MAGIC_WORD, 16'h0002, 16'h0007, 32'hFFFF_FFFF, 1'b0, FILL_RAND, 1'b1,
			cfr_pkg::ST_VERSION},
		'{MAGIC_WORD, 16'h0000, 16'h0007, 32'd3, 1'b0, FILL_RAND, 1'b1, cfr_pkg::ST_VERSION},
		'{MAGIC_WORD, 16'hFFFF, 16'h8001, 32'd3, 1'b0, FILL_RAND, 1'b1, cfr_pkg::ST_VERSION},
		'{MAGIC_WORD, 16'h0001, 16'h00A5, 32'd1048577, 1'b0, FILL_RAND, 1'b1, cfr_pkg::ST_SIZE},
		'{MAGIC_WORD, 16'h0001, 16'hFFFF, 32'hFFFF_FFFF, 1'b0, FILL_RAND, 1'b1, cfr_pkg::ST_SIZE},
		// empty payload, good and bad crc
		'{MAGIC_WORD, 16'h0001, 16'h0000, 32'd0, 1'b0, FILL_RAND, 1'b1, cfr_pkg::ST_OK},
		'{MAGIC_WORD, 16'h0001, 16'hFFFF, 32'd0, 1'b1, FILL_RAND, 1'b1, cfr_pkg::ST_CRC},
		'{MAGIC_WORD, 16'h0001, 16'hFFFF, 32'd1, 1'b0, FILL_ONES, 1'b0, cfr_pkg::ST_OK},
		'{MAGIC_WORD, 16'h0001, 16'h0000, 32'd5, 1'b0, FILL_ZERO, 1'b0, cfr_pkg::ST_OK},
		// payload words already out when the crc fails
		'{MAGIC_WORD, 16'h0001, 16'h5A5A, 32'd7, 1'b1, FILL_RAND, 1'b1, cfr_pkg::ST_CRC},
		'{MAGIC_WORD, 16'h0001, 16'hBEEF, 32'd20, 1'b0, FILL_RAND, 1'b0, cfr_pkg::ST_OK}
	};

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          in_valid = 1'b0;
	logic                          in_stall;
	logic [7:0]                    rx_byte = 8'h00;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	logic [15:0]                   msg_type;
	logic [7:0]                    data_byte;
	logic                          byte_valid;
	logic                          frame_end;
	logic [2:0]                    status;
	logic                          cfg_we = 1'b0;
	logic [cfr_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0]                   cfg_data = '0;

	// parser state of the local prediction, reset values
	logic [4:0]  hdr_pos = '0;
	logic        in_body = 1'b0;
	logic [31:0] hdr_shift = '0;
	logic [15:0] cur_kind = '0;
	logic [31:0] body_left = '0;
	logic [31:0] crc_stored = '0;
	logic [31:0] crc_acc = CRC_SEED;
	logic [2:0]  hdr_err = cfr_pkg::ST_OK;
	logic [15:0] cfg_version = 16'd1;
	logic [31:0] cfg_limit = 32'd1048576;

	cfr_pkg::result_t due_words [$];
	int      bad_words = 0;
	int      bytes_fed = 0;
	int      cycles = 0;
	int      hold_left = 0;
	bit      feed_idle = 1'b1;
	bit      drain_idle = 1'b1;

	crc32c_frame_receiver DUT (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// reflected crc-32c, one data bit folded in per shift
	function automatic logic [31:0] crc32c_next(input logic [31:0] c, input logic [7:0] d);
		logic [31:0] r;
		r = c;
		for (int i = 0; i < 8; i++)
			r = (r >> 1) ^ ((r[0] ^ d[i]) ? POLY_REFL : 32'h0);
		return r;
	endfunction

	function automatic logic [2:0] checksum_status();
		return ((crc_acc ^ CRC_SEED) == crc_stored) ? cfr_pkg::ST_OK : cfr_pkg::ST_CRC;
	endfunction

	function automatic void restart_frame();
		hdr_pos = '0;
		in_body = 1'b0;
		hdr_shift = '0;
		body_left = '0;
		crc_acc = CRC_SEED;
		hdr_err = cfr_pkg::ST_OK;
	endfunction

	// one received byte through the parser; returns 1 when it yields an output word
	function automatic bit deframe_byte(input logic [7:0] b, output cfr_pkg::result_t w);
		w = '0;
		if (in_body) begin
			crc_acc = crc32c_next(crc_acc, b);
			body_left = body_left - 32'd1;
			w.msg_type = cur_kind;
			w.data_byte = b;
			w.byte_valid = 1'b1;
			w.status = cfr_pkg::ST_OK;
			if (body_left == 32'd0) begin
				w.frame_end = 1'b1;
				w.status = checksum_status();
				restart_frame();
			end
			return 1'b1;
		end
		if (hdr_pos < CRC_SPAN)
			crc_acc = crc32c_next(crc_acc, b);
		hdr_shift = {b, hdr_shift[31:8]};
		hdr_pos = hdr_pos + 5'd1;
		case (hdr_pos)
			AT_MAGIC: begin
				if (hdr_shift != MAGIC_WORD && hdr_err == cfr_pkg::ST_OK)
					hdr_err = cfr_pkg::ST_MAGIC;
			end
			AT_VERSION: begin
				if (hdr_shift[31:16] != cfg_version && hdr_err == cfr_pkg::ST_OK)
					hdr_err = cfr_pkg::ST_VERSION;
			end
			AT_KIND: begin
				cur_kind = hdr_shift[31:16];
			end
			AT_LENGTH: begin
				body_left = hdr_shift;
				if (hdr_shift > cfg_limit && hdr_err == cfr_pkg::ST_OK)
					hdr_err = cfr_pkg::ST_SIZE;
			end
			default: ;
		endcase
		if (hdr_pos >= HDR_BYTES) begin
			crc_stored = hdr_shift;
			w.msg_type = cur_kind;
			w.frame_end = 1'b1;
			if (hdr_err != cfr_pkg::ST_OK) begin
				w.status = hdr_err;
				restart_frame();
				return 1'b1;
			end
			if (body_left == 32'd0) begin
				w.status = checksum_status();
				restart_frame();
				return 1'b1;
			end
			in_body = 1'b1;
			hdr_pos = '0;
		end
		return 1'b0;
	endfunction

	// offer one byte, wait for it to be taken, then predict
	task automatic push_word(input logic [7:0] b);
		cfr_pkg::result_t w;
		int gap;
		gap = feed_idle ? $urandom_range(0, 3) : 0;
		repeat (gap) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (deframe_byte(b, w))
			due_words = {due_words, w};
		bytes_fed++;
	endtask

	// hold off input until every predicted word has come out
	task automatic drain_words();
		in_valid <= 1'b0;
		while (due_words.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// finish a broken header with zeros and any payload with random bytes
	task automatic realign();
		while (hdr_pos != 5'd0 || in_body)
			push_word(in_body ? 8'($urandom) : 8'h00);
	endtask

	// header little-endian, crc over the first twelve header bytes and the payload
	task automatic offer_frame(input logic [31:0] magic, input logic [15:0] version,
			input logic [15:0] kind, input logic [31:0] length, input bit bad_crc,
			input fill_t fill, input int cut);
		logic [7:0]  hdr [HDR_BYTES];
		logic [7:0]  body [$];
		logic [31:0] acc;
		logic [31:0] stored;
		int          n;
		n = (length <= MAX_BODY) ? int'(length) : 0;
		for (int i = 0; i < n; i++) begin
			case (fill)
				FILL_ZERO: body = {body, 8'h00};
				FILL_ONES: body = {body, 8'hFF};
				default:   body = {body, 8'($urandom)};
			endcase
		end
		for (int i = 0; i < 4; i++) begin
			hdr[i] = magic[8*i +: 8];
			hdr[8 + i] = length[8*i +: 8];
		end
		for (int i = 0; i < 2; i++) begin
			hdr[4 + i] = version[8*i +: 8];
			hdr[6 + i] = kind[8*i +: 8];
		end
		acc = CRC_SEED;
		for (int i = 0; i < CRC_SPAN; i++)
			acc = crc32c_next(acc, hdr[i]);
		foreach (body[i])
			acc = crc32c_next(acc, body[i]);
		stored = acc ^ CRC_SEED;
		if (bad_crc)
			stored = stored ^ (32'd1 << $urandom_range(0, 31));
		for (int i = 0; i < 4; i++)
			hdr[12 + i] = stored[8*i +: 8];
		for (int i = 0; i < cut; i++)
			push_word(hdr[i]);
		if (cut < HDR_BYTES) begin
			realign();
		end else begin
			n = 0;
			while (in_body) begin
				push_word(n < body.size() ? body[n] : 8'($urandom));
				n++;
			end
		end
	endtask

	// mostly well-formed frames, some with a faulted header field or crc
	task automatic random_frame();
		logic [31:0] magic;
		logic [31:0] length;
		logic [15:0] version;
		logic [15:0] kind;
		fill_t       fill;
		int          r;
		magic = MAGIC_WORD;
		version = cfg_version;
		if ($urandom_range(0, 99) < 5)
			magic = magic ^ (32'd1 << $urandom_range(0, 31));
		if ($urandom_range(0, 99) < 8)
			version = version ^ 16'($urandom_range(1, 16'hFFFF));
		r = $urandom_range(0, 99);
		if (r < 60)
			length = $urandom_range(0, 12);
		else if (r < 75)
			length = $urandom_range(13, MAX_BODY);
		else if (r < 88 && cfg_limit < MAX_BODY)
			length = cfg_limit + $urandom_range(0, 1);
		else if (r < 95 && cfg_limit != 32'hFFFF_FFFF)
			length = cfg_limit + 32'd1 + ($urandom % (32'hFFFF_FFFF - cfg_limit));
		else
			length = $urandom_range(0, 3);
		r = $urandom_range(0, 9);
		kind = (r == 0) ? 16'h0000 : (r == 1) ? 16'hFFFF : 16'($urandom);
		r = $urandom_range(0, 9);
		fill = (r == 0) ? FILL_ZERO : (r == 1) ? FILL_ONES : FILL_RAND;
		offer_frame(magic, version, kind, length, $urandom_range(0, 9) == 0, fill, HDR_BYTES);
	endtask

	// both registers written back to back while idle
	task automatic set_config(input logic [15:0] version, input logic [31:0] limit);
		drain_words();
		cfg_we <= 1'b1;
		cfg_index <= cfr_pkg::CFG_EXPECTED_VERSION;
		cfg_data <= {16'($urandom), version};
		@(posedge clk);
		cfg_index <= cfr_pkg::CFG_MAX_PAYLOAD;
		cfg_data <= limit;
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_version = version;
		cfg_limit = limit;
	endtask

	// stimulus
	initial begin
		cfr_pkg::result_t tail;
		int      r;
		int      mark;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < ROWS; i++) begin
			offer_frame(plan[i].magic, plan[i].version, plan[i].kind, plan[i].length,
				plan[i].bad_crc, plan[i].fill, HDR_BYTES);
			if (plan[i].typed) begin
				tail = due_words.pop_back();
				tail.status = plan[i].want;
				due_words = {due_words, tail};
			end
		end

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				1: set_config(16'h0000, 32'h0000_0000);
				2: set_config(16'hFFFF, 32'hFFFF_FFFF);
				3: set_config(16'($urandom), $urandom_range(0, 40));
				4: set_config(16'($urandom), $urandom);
				5: set_config(16'h0001, 32'd20);
				default: ;
			endcase
			mark = bytes_fed;
			while (bytes_fed - mark < PHASE_BYTES) begin
				feed_idle = ($urandom_range(0, 3) != 0);
				drain_idle = ($urandom_range(0, 3) != 0);
				r = $urandom_range(0, 99);
				if (r < 3) begin
					drain_words();
				end else if (r < 10) begin
					repeat ($urandom_range(1, 24)) push_word(8'($urandom));
					realign();
				end else if (r < 16) begin
					offer_frame(MAGIC_WORD, cfg_version, 16'($urandom), $urandom_range(0, 12),
						1'b0, FILL_RAND, $urandom_range(1, HDR_BYTES - 1));
				end else begin
					random_frame();
				end
			end
		end

		drain_words();
		if (bad_words == 0)
			$display("[crc32c_frame_receiver] OK");
		else
			$display("[crc32c_frame_receiver] ERROR");
		$finish;
	end

	// output side: random stall, compare each taken word with the oldest prediction
	always @(posedge clk) begin
		cfr_pkg::result_t got;
		cfr_pkg::result_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				got = {msg_type, data_byte, byte_valid, frame_end, status};
				if (due_words.size() == 0) begin
					bad_words++;
					if (bad_words <= 10)
						$display("unexpected word: type %h data %h valid %b end %b status %0d",
							got.msg_type, got.data_byte, got.byte_valid, got.frame_end,
							got.status);
				end else begin
					want = due_words.pop_front();
					if (got.msg_type !== want.msg_type || got.data_byte !== want.data_byte ||
							got.byte_valid !== want.byte_valid ||
							got.frame_end !== want.frame_end || got.status !== want.status) begin
						bad_words++;
						if (bad_words <= 10)
							$display({"word mismatch: expected type %h data %h valid %b end %b",
								" status %0d, got type %h data %h valid %b end %b status %0d"},
								want.msg_type, want.data_byte, want.byte_valid, want.frame_end,
								want.status, got.msg_type, got.data_byte, got.byte_valid,
								got.frame_end, got.status);
					end
				end
				hold_left = drain_idle ? $urandom_range(0, 3) : 0;
			end else if (hold_left == 0 && drain_idle && $urandom_range(0, 7) == 0) begin
				hold_left = 1;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("[crc32c_frame_receiver] ERROR");
			$finish;
		end
	end

endmodule
